// ===== rtl/core/rcsfp_pkg.sv =====
// rcsfp_pkg: shared constants, types and helpers for the servo frame parser.
// Used by rcsfp_ctrl, rcsfp_dpath and rc_servo_frame_parser_unit.
package rcsfp_pkg;

  localparam int DefFrameBytes = 32;
  localparam int DefChannels   = 14;

  localparam int ByteW     = 8;
  localparam int WordW     = 16;
  localparam int CountW    = 32;
  localparam int ChIdxW    = 4;
  localparam int StoreDepth = 32;
  localparam int StoreAw   = 5;
  // byte address of a channel word, wide enough for 2 + 2 * 13 + 1
  localparam int ByteAddrW = 6;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegHeader  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCommand = 1'b1;

  localparam logic [ByteW-1:0] HeaderReset  = 8'd32;
  localparam logic [ByteW-1:0] CommandReset = 8'd64;

  // controller -> datapath
  typedef struct packed {
    logic byte_take;  // input request accepted this cycle
    logic ch_clr;     // restart channel counter for a new good frame
    logic rd_en;      // read one frame byte
    logic rd_hi;      // read the high byte of the current channel
    logic lo_cap;     // capture low byte from read data
    logic load_out;   // load the output register
    logic ch_inc;     // step to next channel
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_good;  // byte on the input closes a frame with a good checksum
    logic out_free;    // output register can take a new result
    logic last_ch;     // current channel is the last one
  } ctrl_sts_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == {CountW{1'b1}}) ? v : v + CountW'(1);
  endfunction

endpackage

// ===== rtl/core/rcsfp_ctrl.sv =====
// rcsfp_ctrl: sequencer for byte intake and channel read-out.
// Depends on rcsfp_pkg for the command and status structs.
module rcsfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcsfp_pkg::ctrl_sts_t sts_i,
  output rcsfp_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IN    = 2'd0;
  localparam logic [1:0] S_RD_LO = 2'd1;
  localparam logic [1:0] S_RD_HI = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_take;

  assign in_take    = in_valid_i && (state_q == S_IN);
  assign in_stall_o = (state_q != S_IN);

  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_take = in_take;
    cmd_o.ch_clr    = in_take && sts_i.frame_good;
    cmd_o.rd_en     = (state_q == S_RD_LO) || (state_q == S_RD_HI);
    cmd_o.rd_hi     = (state_q == S_RD_HI);
    cmd_o.lo_cap    = (state_q == S_RD_HI);
    cmd_o.load_out  = (state_q == S_LOAD) && sts_i.out_free;
    cmd_o.ch_inc    = cmd_o.load_out && !sts_i.last_ch;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IN: begin
        if (in_take && sts_i.frame_good) begin
          state_d = S_RD_LO;
        end
      end
      S_RD_LO: state_d = S_RD_HI;
      S_RD_HI: state_d = S_LOAD;
      S_LOAD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last_ch ? S_IN : S_RD_LO;
        end
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("output loaded while occupied");

  a_good_frame_starts_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && sts_i.frame_good) |=> (state_q == S_RD_LO))
    else $error("good frame did not start read-out");

  a_no_read_in_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.byte_take |-> !cmd_o.rd_en && !cmd_o.load_out)
    else $error("byte intake overlaps read-out");

endmodule

// ===== rtl/core/rcsfp_dpath.sv =====
// rcsfp_dpath: frame store, running checksum, error counters and output register.
// Depends on rcsfp_pkg; driven by rcsfp_ctrl commands.
module rcsfp_dpath #(
  parameter int FRAME_BYTES = rcsfp_pkg::DefFrameBytes,
  parameter int CHANNELS    = rcsfp_pkg::DefChannels
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcsfp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rcsfp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [rcsfp_pkg::ByteW-1:0]         rx_byte_i,
  input  rcsfp_pkg::ctrl_cmd_t                cmd_i,
  output rcsfp_pkg::ctrl_sts_t                sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rcsfp_pkg::ChIdxW-1:0]        channel_index_o,
  output logic [rcsfp_pkg::WordW-1:0]         channel_value_o,
  output logic                                last_channel_o,
  output logic [rcsfp_pkg::CountW-1:0]        good_frames_o,
  output logic [rcsfp_pkg::CountW-1:0]        header_error_total_o,
  output logic [rcsfp_pkg::CountW-1:0]        checksum_error_total_o
);

  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_BYTES - 1);
  localparam logic [PosW-1:0] PosCksLo = PosW'(FRAME_BYTES - 2);
  localparam logic [rcsfp_pkg::ChIdxW-1:0] ChLast = rcsfp_pkg::ChIdxW'(CHANNELS - 1);

  logic [rcsfp_pkg::ByteW-1:0]  hdr_q, cmd_q;
  logic [PosW-1:0]              pos_q, pos_d;
  logic [rcsfp_pkg::WordW-1:0]  sum_q, sum_d;
  logic [rcsfp_pkg::ByteW-1:0]  cks_lo_q;
  logic [rcsfp_pkg::CountW-1:0] good_cnt_q, hdr_err_q, cks_err_q;
  logic [rcsfp_pkg::ChIdxW-1:0] ch_q;
  logic [rcsfp_pkg::ByteW-1:0]  frame_mem [rcsfp_pkg::StoreDepth];
  logic [rcsfp_pkg::ByteW-1:0]  rd_data_q, lo_q;
  logic                         rd_ok_q;
  logic                         out_valid_q;

  logic                              hdr_hit, at_first, cmd_bad, at_end, cks_ok, restart;
  logic                              wr_en;
  logic [rcsfp_pkg::StoreAw-1:0]     wr_addr;
  logic [rcsfp_pkg::ByteAddrW-1:0]   rd_addr;
  logic                              out_take;

  assign hdr_hit  = (rx_byte_i == hdr_q);
  assign at_first = (pos_q == '0);
  assign cmd_bad  = (pos_q == PosW'(1)) && (rx_byte_i != cmd_q);
  assign at_end   = (pos_q == PosLast);
  // expected word is 0xFFFF minus the sum, i.e. its complement
  assign cks_ok   = ({rx_byte_i, cks_lo_q} == ~sum_q);
  assign restart  = at_first || cmd_bad;

  assign wr_en   = cmd_i.byte_take && (!restart || hdr_hit);
  assign wr_addr = restart ? '0 : rcsfp_pkg::StoreAw'(pos_q);

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (cmd_i.byte_take) begin
      if (restart) begin
        pos_d = hdr_hit ? PosW'(1) : '0;
        sum_d = rcsfp_pkg::WordW'(rx_byte_i);
      end else begin
        pos_d = at_end ? '0 : pos_q + PosW'(1);
        if (pos_q < PosCksLo) begin
          sum_d = sum_q + rcsfp_pkg::WordW'(rx_byte_i);
        end
      end
    end
  end

  // channel word sits at byte 2 + 2 * ch; bytes beyond the frame read as zero
  assign rd_addr = rcsfp_pkg::ByteAddrW'(2) + {1'b0, ch_q, 1'b0}
                 + rcsfp_pkg::ByteAddrW'(cmd_i.rd_hi);

  assign out_take = out_valid_q && !out_stall_i;

  assign sts_o.frame_good = at_end && cks_ok;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.last_ch    = (ch_q == ChLast);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= frame_mem[rd_addr[rcsfp_pkg::StoreAw-1:0]];
      rd_ok_q   <= (rd_addr < rcsfp_pkg::ByteAddrW'(FRAME_BYTES));
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (cmd_i.byte_take && (pos_q == PosCksLo)) begin
      cks_lo_q <= rx_byte_i;
    end
    if (cmd_i.lo_cap) begin
      lo_q <= rd_ok_q ? rd_data_q : '0;
    end
    if (cmd_i.load_out) begin
      channel_index_o        <= ch_q;
      channel_value_o        <= {(rd_ok_q ? rd_data_q : '0), lo_q};
      last_channel_o         <= (ch_q == ChLast);
      good_frames_o          <= good_cnt_q;
      header_error_total_o   <= hdr_err_q;
      checksum_error_total_o <= cks_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= rcsfp_pkg::HeaderReset;
      cmd_q       <= rcsfp_pkg::CommandReset;
      pos_q       <= '0;
      good_cnt_q  <= '0;
      hdr_err_q   <= '0;
      cks_err_q   <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rcsfp_pkg::RegHeader:  hdr_q <= cfg_data_i;
          rcsfp_pkg::RegCommand: cmd_q <= cfg_data_i;
          default: ;
        endcase
      end
      pos_q <= pos_d;
      if (cmd_i.byte_take && cmd_bad) begin
        hdr_err_q <= rcsfp_pkg::sat_inc(hdr_err_q);
      end
      if (cmd_i.byte_take && !restart && at_end) begin
        if (cks_ok) begin
          good_cnt_q <= rcsfp_pkg::sat_inc(good_cnt_q);
        end else begin
          cks_err_q <= rcsfp_pkg::sat_inc(cks_err_q);
        end
      end
      if (cmd_i.ch_clr) begin
        ch_q <= '0;
      end else if (cmd_i.ch_inc) begin
        ch_q <= ch_q + rcsfp_pkg::ChIdxW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("byte position beyond frame");

  a_good_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_cnt_q >= $past(good_cnt_q))
    else $error("good frame count went down");

  a_ch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q <= ChLast)
    else $error("channel counter out of range");

endmodule

// ===== rtl/core/rc_servo_frame_parser_unit.sv =====
// rc_servo_frame_parser_unit: top level of the serial servo frame parser.
// Instantiates rcsfp_ctrl and rcsfp_dpath; uses rcsfp_pkg.
//
// Bytes are taken one per cycle while the parser collects a frame; a frame
// opens with the header byte, must carry the command byte second, and is
// checked on its last byte against the complement of the 16-bit byte sum.
// After the closing byte of a good frame, input stall stays high while the
// CHANNELS channel requests are read out of the frame store: its single read
// port fetches two bytes per channel, low byte then high byte, and the word is
// then loaded into the output register once that register is free.
// The last channel sits in the output register while new bytes are accepted.
module rc_servo_frame_parser_unit #(
  parameter int FRAME_BYTES = rcsfp_pkg::DefFrameBytes,
  parameter int CHANNELS    = rcsfp_pkg::DefChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcsfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcsfp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rcsfp_pkg::ByteW-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rcsfp_pkg::ChIdxW-1:0]   channel_index_o,
  output logic [rcsfp_pkg::WordW-1:0]    channel_value_o,
  output logic                           last_channel_o,
  output logic [rcsfp_pkg::CountW-1:0]   good_frames_o,
  output logic [rcsfp_pkg::CountW-1:0]   header_error_total_o,
  output logic [rcsfp_pkg::CountW-1:0]   checksum_error_total_o
);

  rcsfp_pkg::ctrl_cmd_t cmd;
  rcsfp_pkg::ctrl_sts_t sts;

  rcsfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcsfp_dpath #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_dpath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .rx_byte_i              (rx_byte_i),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .channel_index_o        (channel_index_o),
    .channel_value_o        (channel_value_o),
    .last_channel_o         (last_channel_o),
    .good_frames_o          (good_frames_o),
    .header_error_total_o   (header_error_total_o),
    .checksum_error_total_o (checksum_error_total_o)
  );

endmodule
